### rtl/foc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the FOC current loop: fixed-point widths,
// polynomial sine coefficients, register indexes and controller commands.
package foc_pkg;

  localparam int P_W       = 50;   // shared multiplier product width
  localparam int A_W       = 30;   // multiplier operand A width
  localparam int B_W       = 20;   // multiplier operand B width
  localparam int TRIG_SH   = 15;   // Q1.15 sine/cosine
  localparam int GAIN_SH   = 16;   // Q0.16 gains
  localparam int STEP_W    = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = 5'd31;

  localparam logic signed [A_W-1:0] INV_SQRT3 = 30'sd37837;
  localparam logic signed [A_W-1:0] SIN_A     = 30'sd421657428;
  localparam logic signed [A_W-1:0] SIN_B     = 30'sd172226216;
  localparam logic signed [A_W-1:0] SIN_C     = 30'sd19004244;

  typedef enum logic [2:0] {
    CFG_POLE_PAIRS    = 3'd0,
    CFG_THREE_SHUNT   = 3'd1,
    CFG_GAIN_P        = 3'd2,
    CFG_GAIN_I        = 3'd3,
    CFG_VOLTAGE_LIMIT = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    A_PP, A_INV, A_UF, A_UB, A_C, A_TF, A_TB, A_COS, A_SIN, A_GP, A_GI
  } a_sel_e;

  typedef enum logic [3:0] {
    B_MECH, B_X, B_UF, B_UB, B_U2F, B_U2B, B_IA, B_BETA,
    B_DD, B_ED, B_DQ, B_EQ, B_VD, B_VQ
  } b_sel_e;

  typedef enum logic [4:0] {
    WB_NONE, WB_X, WB_ELEC, WB_BETA_U, WB_U2F, WB_U2B, WB_TF_B, WB_TB_B,
    WB_TF_A, WB_TB_A, WB_FW, WB_BW, WB_SC, WB_ACC_LD, WB_ACC_NEG, WB_D,
    WB_Q, WB_ERR, WB_ACC_ADD, WB_DACC, WB_QACC, WB_VDQ, WB_VA, WB_VB
  } wb_e;

  typedef struct packed {
    logic   load;
    logic   publish;
    a_sel_e a_sel;
    b_sel_e b_sel;
    wb_e    wb;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } stat_t;

  // Round half up at TRIG_SH bits and saturate to 16 bits.
  function automatic logic signed [15:0] rnd_sat(input logic signed [P_W:0] v);
    logic signed [P_W:0] r;
    r = (v + (P_W+1)'(1 << (TRIG_SH - 1))) >>> TRIG_SH;
    if (r > (P_W+1)'(32767)) begin
      rnd_sat = 16'sh7fff;
    end else if (r < -(P_W+1)'(32768)) begin
      rnd_sat = 16'sh8000;
    end else begin
      rnd_sat = r[15:0];
    end
  endfunction

endpackage

### rtl/foc_current_loop_top.sv
`timescale 1ns / 1ps
// FOC current loop, top level: joins the sequencer and the datapath.
// Depends on foc_pkg, foc_ctrl and foc_dp.

// One item (a PWM tick) runs through a fixed 31-step schedule on a single
// shared 30x20 multiplier: angle, Clarke, polynomial sine/cosine, Park, two
// incremental PI loops and inverse Park. A new item is accepted only once the
// previous result has been published, which waits while the output register
// is still full; a finished result waits in an output register while the next
// item is accepted. Configuration is to be written through cfg_we_i/cfg_idx_i/
// cfg_data_i while no item is in flight; the block itself does not enforce this.
module foc_current_loop_top import foc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [11:0] phase_a_current_i,
  input  logic signed [11:0] phase_b_current_i,
  input  logic signed [11:0] phase_c_current_i,
  input  logic [15:0]        mech_angle_i,
  input  logic [2:0]         pwm_sector_i,
  input  logic signed [15:0] target_d_i,
  input  logic signed [15:0] target_q_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] volt_alpha_o,
  output logic signed [15:0] volt_beta_o,
  output logic signed [15:0] meas_d_o,
  output logic signed [15:0] meas_q_o,
  output logic [15:0]        elec_angle_o,
  output logic [15:0]        rotor_angle_o
);

  cmd_t  cmd;
  stat_t stat;

  foc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  foc_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .phase_a_current_i (phase_a_current_i),
    .phase_b_current_i (phase_b_current_i),
    .phase_c_current_i (phase_c_current_i),
    .mech_angle_i      (mech_angle_i),
    .pwm_sector_i      (pwm_sector_i),
    .target_d_i        (target_d_i),
    .target_q_i        (target_q_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .volt_alpha_o      (volt_alpha_o),
    .volt_beta_o       (volt_beta_o),
    .meas_d_o          (meas_d_o),
    .meas_q_o          (meas_q_o),
    .elec_angle_o      (elec_angle_o),
    .rotor_angle_o     (rotor_angle_o)
  );

endmodule

### rtl/foc_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the FOC current loop: walks a fixed step schedule that drives
// the shared multiplier and write-back of foc_dp. Uses foc_pkg.
module foc_ctrl import foc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  cmd_t              sched;

  // Product of step k is written back at step k+1.
  always_comb begin
    sched = '{load: 1'b0, publish: 1'b0, a_sel: A_PP, b_sel: B_MECH, wb: WB_NONE};
    unique case (step_q)
      5'd1:  begin sched.a_sel = A_PP;  sched.b_sel = B_MECH; sched.wb = WB_X;      end
      5'd2:  begin sched.a_sel = A_INV; sched.b_sel = B_X;    sched.wb = WB_ELEC;   end
      5'd3:  begin                                            sched.wb = WB_BETA_U; end
      5'd4:  begin sched.a_sel = A_UF;  sched.b_sel = B_UF;                         end
      5'd5:  begin sched.a_sel = A_UB;  sched.b_sel = B_UB;   sched.wb = WB_U2F;    end
      5'd6:  begin sched.a_sel = A_C;   sched.b_sel = B_U2F;  sched.wb = WB_U2B;    end
      5'd7:  begin sched.a_sel = A_C;   sched.b_sel = B_U2B;  sched.wb = WB_TF_B;   end
      5'd8:  begin sched.a_sel = A_TF;  sched.b_sel = B_U2F;  sched.wb = WB_TB_B;   end
      5'd9:  begin sched.a_sel = A_TB;  sched.b_sel = B_U2B;  sched.wb = WB_TF_A;   end
      5'd10: begin sched.a_sel = A_TF;  sched.b_sel = B_UF;   sched.wb = WB_TB_A;   end
      5'd11: begin sched.a_sel = A_TB;  sched.b_sel = B_UB;   sched.wb = WB_FW;     end
      5'd12: begin                                            sched.wb = WB_BW;     end
      5'd13: begin                                            sched.wb = WB_SC;     end
      5'd14: begin sched.a_sel = A_COS; sched.b_sel = B_IA;                         end
      5'd15: begin sched.a_sel = A_SIN; sched.b_sel = B_BETA; sched.wb = WB_ACC_LD; end
      5'd16: begin sched.a_sel = A_SIN; sched.b_sel = B_IA;   sched.wb = WB_D;      end
      5'd17: begin sched.a_sel = A_COS; sched.b_sel = B_BETA; sched.wb = WB_ACC_NEG; end
      5'd18: begin                                            sched.wb = WB_Q;      end
      5'd19: begin                                            sched.wb = WB_ERR;    end
      5'd20: begin sched.a_sel = A_GP;  sched.b_sel = B_DD;                         end
      5'd21: begin sched.a_sel = A_GI;  sched.b_sel = B_ED;   sched.wb = WB_ACC_LD; end
      5'd22: begin sched.a_sel = A_GP;  sched.b_sel = B_DQ;   sched.wb = WB_ACC_ADD; end
      5'd23: begin sched.a_sel = A_GI;  sched.b_sel = B_EQ;   sched.wb = WB_DACC;   end
      5'd24: begin                                            sched.wb = WB_ACC_ADD; end
      5'd25: begin                                            sched.wb = WB_QACC;   end
      5'd26: begin                                            sched.wb = WB_VDQ;    end
      5'd27: begin sched.a_sel = A_COS; sched.b_sel = B_VD;                         end
      5'd28: begin sched.a_sel = A_SIN; sched.b_sel = B_VQ;   sched.wb = WB_ACC_LD; end
      5'd29: begin sched.a_sel = A_SIN; sched.b_sel = B_VD;   sched.wb = WB_VA;     end
      5'd30: begin sched.a_sel = A_COS; sched.b_sel = B_VQ;   sched.wb = WB_ACC_LD; end
      5'd31: begin                                            sched.wb = WB_VB;     end
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '{load: 1'b0, publish: 1'b0, a_sel: A_PP, b_sel: B_MECH, wb: WB_NONE};
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
          step_d     = STEP_W'(1);
        end
      end
      ST_RUN: begin
        cmd_o  = sched;
        step_d = step_q + STEP_W'(1);
        if (step_q == LAST_STEP) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (!stat_i.out_full) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

### rtl/foc_dp.sv
`timescale 1ns / 1ps
// Datapath of the FOC current loop: configuration registers, input latch,
// shared multiplier, write-back registers, PI state and output register.
module foc_dp import foc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic signed [11:0] phase_a_current_i,
  input  logic signed [11:0] phase_b_current_i,
  input  logic signed [11:0] phase_c_current_i,
  input  logic [15:0]        mech_angle_i,
  input  logic [2:0]         pwm_sector_i,
  input  logic signed [15:0] target_d_i,
  input  logic signed [15:0] target_q_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] volt_alpha_o,
  output logic signed [15:0] volt_beta_o,
  output logic signed [15:0] meas_d_o,
  output logic signed [15:0] meas_q_o,
  output logic [15:0]        elec_angle_o,
  output logic [15:0]        rotor_angle_o
);

  localparam logic [2:0] SEC_1 = 3'd1;
  localparam logic [2:0] SEC_2 = 3'd2;
  localparam logic [2:0] SEC_3 = 3'd3;
  localparam logic [2:0] SEC_6 = 3'd6;

  // configuration
  logic [5:0]  pp_q;
  logic        shunt3_q;
  logic [15:0] gp_q, gi_q;
  logic [14:0] vlim_q;

  // item payload and intermediates
  logic signed [13:0] ia_q, ib_q, beta_q;
  logic [15:0]        mech_q, elec_q;
  logic signed [15:0] td_q, tq_q, s_q, c_q, fw_q, bw_q, d_q, q_q, va_q, vb_q;
  logic signed [14:0] x_q;
  logic [18:0]        uf_q, ub_q, u2f_q, u2b_q;
  logic signed [A_W-1:0] tf_q, tb_q;
  logic signed [P_W-1:0] p_q, acc_q;
  logic signed [16:0] ed_q, eq_q, vd_q, vq_q;
  logic signed [17:0] dd_q, dq_q;

  // loop state
  logic signed [31:0] dacc_q, qacc_q;
  logic signed [17:0] dprev_q, qprev_q;

  // output register
  logic               ovalid_q;
  logic signed [15:0] o_va_q, o_vb_q, o_d_q, o_q_q;
  logic [15:0]        o_elec_q, o_mech_q;

  logic signed [A_W-1:0] a_mux;
  logic signed [B_W-1:0] b_mux;
  logic signed [13:0]    ia_ld, ib_ld, ra, rb, rc;
  logic signed [P_W:0]   acc_sum, acc_dif, pi_sum, lim;
  logic signed [P_W-1:0] beta_r;
  logic [A_W-1:0]        sh18;
  logic [16:0]           trig_r;
  logic signed [15:0]    trig;
  logic signed [16:0]    ed_n, eq_n;
  logic signed [32:0]    vd_r, vq_r;

  // skip rebuilding phase C: only A and B feed the Clarke transform
  always_comb begin
    ra = $signed({{2{phase_a_current_i[11]}}, phase_a_current_i});
    rb = $signed({{2{phase_b_current_i[11]}}, phase_b_current_i});
    rc = $signed({{2{phase_c_current_i[11]}}, phase_c_current_i});
    ia_ld = ra;
    ib_ld = rb;
    if (shunt3_q) begin
      if (pwm_sector_i == SEC_1 || pwm_sector_i == SEC_6) begin
        ia_ld = -rb - rc;
      end else if (pwm_sector_i == SEC_2 || pwm_sector_i == SEC_3) begin
        ib_ld = -ra - rc;
      end
    end
  end

  always_comb begin
    unique case (cmd_i.a_sel)
      A_PP:    a_mux = $signed({{(A_W-6){1'b0}}, pp_q});
      A_INV:   a_mux = INV_SQRT3;
      A_UF:    a_mux = $signed({{(A_W-19){1'b0}}, uf_q});
      A_UB:    a_mux = $signed({{(A_W-19){1'b0}}, ub_q});
      A_C:     a_mux = SIN_C;
      A_TF:    a_mux = tf_q;
      A_TB:    a_mux = tb_q;
      A_COS:   a_mux = A_W'(c_q);
      A_SIN:   a_mux = A_W'(s_q);
      A_GP:    a_mux = $signed({{(A_W-16){1'b0}}, gp_q});
      A_GI:    a_mux = $signed({{(A_W-16){1'b0}}, gi_q});
      default: a_mux = '0;
    endcase
    unique case (cmd_i.b_sel)
      B_MECH:  b_mux = $signed({{(B_W-16){1'b0}}, mech_q});
      B_X:     b_mux = B_W'(x_q);
      B_UF:    b_mux = $signed({1'b0, uf_q});
      B_UB:    b_mux = $signed({1'b0, ub_q});
      B_U2F:   b_mux = $signed({1'b0, u2f_q});
      B_U2B:   b_mux = $signed({1'b0, u2b_q});
      B_IA:    b_mux = B_W'(ia_q);
      B_BETA:  b_mux = B_W'(beta_q);
      B_DD:    b_mux = B_W'(dd_q);
      B_ED:    b_mux = B_W'(ed_q);
      B_DQ:    b_mux = B_W'(dq_q);
      B_EQ:    b_mux = B_W'(eq_q);
      B_VD:    b_mux = B_W'(vd_q);
      B_VQ:    b_mux = B_W'(vq_q);
      default: b_mux = '0;
    endcase
  end

  always_comb begin
    acc_sum = (P_W+1)'(acc_q) + (P_W+1)'(p_q);
    acc_dif = (P_W+1)'(acc_q) - (P_W+1)'(p_q);
    beta_r  = (p_q + P_W'(32768)) >>> 16;
    sh18    = p_q[47:18];
    // sine polynomial output: round at 13 bits, cap at the top code
    trig_r  = 17'((sh18 + A_W'(4096)) >> 13);
    trig    = (trig_r > 17'd32767) ? 16'sh7fff : $signed(trig_r[15:0]);
    ed_n    = 17'(td_q) - 17'(d_q);
    eq_n    = 17'(tq_q) - 17'(q_q);
    lim     = $signed({{(P_W+1-31){1'b0}}, vlim_q, {GAIN_SH{1'b0}}});
    pi_sum  = (P_W+1)'(cmd_i.wb == WB_DACC ? dacc_q : qacc_q) + (P_W+1)'(acc_q);
    vd_r    = (33'(dacc_q) + 33'sd32768);
    vq_r    = (33'(qacc_q) + 33'sd32768);
  end

  function automatic logic signed [31:0] clamp_lim(input logic signed [P_W:0] v,
                                                   input logic signed [P_W:0] l);
    if (v > l) begin
      clamp_lim = l[31:0];
    end else if (v < -l) begin
      clamp_lim = 32'(-l);
    end else begin
      clamp_lim = v[31:0];
    end
  endfunction

  // configuration registers and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q     <= 6'd7;
      shunt3_q <= 1'b1;
      gp_q     <= 16'd2319;
      gi_q     <= 16'd2319;
      vlim_q   <= 15'd28360;
      dacc_q   <= '0;
      qacc_q   <= '0;
      dprev_q  <= '0;
      qprev_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_POLE_PAIRS:    pp_q     <= cfg_data_i[5:0];
          CFG_THREE_SHUNT:   shunt3_q <= cfg_data_i[0];
          CFG_GAIN_P:        gp_q     <= cfg_data_i;
          CFG_GAIN_I:        gi_q     <= cfg_data_i;
          CFG_VOLTAGE_LIMIT: vlim_q   <= cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (cmd_i.wb == WB_ERR) begin
        dprev_q <= 18'(ed_n);
        qprev_q <= 18'(eq_n);
      end
      if (cmd_i.wb == WB_DACC) begin
        dacc_q <= clamp_lim(pi_sum, lim);
      end
      if (cmd_i.wb == WB_QACC) begin
        qacc_q <= clamp_lim(pi_sum, lim);
      end
      if (cmd_i.publish) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    p_q <= a_mux * b_mux;
    if (cmd_i.load) begin
      ia_q   <= ia_ld;
      ib_q   <= ib_ld;
      mech_q <= mech_angle_i;
      td_q   <= target_d_i;
      tq_q   <= target_q_i;
    end
    unique case (cmd_i.wb)
      WB_X:      x_q    <= 15'(ia_q) + $signed({ib_q, 1'b0});
      WB_ELEC:   elec_q <= p_q[15:0];
      WB_BETA_U: begin
        beta_q <= beta_r[13:0];
        uf_q   <= {1'b0, elec_q[13:0], 4'b0};
        ub_q   <= 19'h40000 - {1'b0, elec_q[13:0], 4'b0};
      end
      WB_U2F:    u2f_q <= p_q[36:18];
      WB_U2B:    u2b_q <= p_q[36:18];
      WB_TF_B:   tf_q  <= SIN_B - $signed(sh18);
      WB_TB_B:   tb_q  <= SIN_B - $signed(sh18);
      WB_TF_A:   tf_q  <= SIN_A - $signed(sh18);
      WB_TB_A:   tb_q  <= SIN_A - $signed(sh18);
      WB_FW:     fw_q  <= trig;
      WB_BW:     bw_q  <= trig;
      WB_SC: begin
        unique case (elec_q[15:14])
          2'd0: begin s_q <= fw_q;  c_q <= bw_q;  end
          2'd1: begin s_q <= bw_q;  c_q <= -fw_q; end
          2'd2: begin s_q <= -fw_q; c_q <= -bw_q; end
          default: begin s_q <= -bw_q; c_q <= fw_q; end
        endcase
      end
      WB_ACC_LD:  acc_q <= p_q;
      WB_ACC_NEG: acc_q <= -p_q;
      WB_ACC_ADD: acc_q <= acc_sum[P_W-1:0];
      WB_D:       d_q   <= rnd_sat(acc_sum);
      WB_Q:       q_q   <= rnd_sat(acc_sum);
      WB_ERR: begin
        ed_q <= ed_n;
        eq_q <= eq_n;
        dd_q <= 18'(ed_n) - dprev_q;
        dq_q <= 18'(eq_n) - qprev_q;
      end
      WB_DACC:    acc_q <= p_q;
      WB_VDQ: begin
        vd_q <= vd_r[32:16];
        vq_q <= vq_r[32:16];
      end
      WB_VA:      va_q <= rnd_sat(acc_dif);
      WB_VB:      vb_q <= rnd_sat(acc_sum);
      default: ;
    endcase
    if (cmd_i.publish) begin
      o_va_q   <= va_q;
      o_vb_q   <= vb_q;
      o_d_q    <= d_q;
      o_q_q    <= q_q;
      o_elec_q <= elec_q;
      o_mech_q <= mech_q;
    end
  end

  assign stat_o.out_full = ovalid_q;
  assign out_valid_o     = ovalid_q;
  assign volt_alpha_o    = o_va_q;
  assign volt_beta_o     = o_vb_q;
  assign meas_d_o        = o_d_q;
  assign meas_q_o        = o_q_q;
  assign elec_angle_o    = o_elec_q;
  assign rotor_angle_o   = o_mech_q;

endmodule

### sim/tb_foc_current_loop_top.sv
`timescale 1ns / 1ps
// Testbench of foc_current_loop_top: directed and random PWM ticks through
// the valid/ready channels, checked against an in-bench predictor of the
// current loop. Depends on foc_pkg and the foc_current_loop_top RTL.

class foc_scoreboard;
  logic [15:0] pend_va[$], pend_vb[$], pend_d[$], pend_q[$], pend_el[$], pend_rot[$];
  int errors = 0;

  function void note(logic [15:0] va, logic [15:0] vb, logic [15:0] d, logic [15:0] q,
                     logic [15:0] el, logic [15:0] rot);
    pend_va.push_back(va); pend_vb.push_back(vb); pend_d.push_back(d);
    pend_q.push_back(q); pend_el.push_back(el); pend_rot.push_back(rot);
  endfunction

  function void check(logic [15:0] va, logic [15:0] vb, logic [15:0] d, logic [15:0] q,
                      logic [15:0] el, logic [15:0] rot);
    logic [15:0] e_va, e_vb, e_d, e_q, e_el, e_rot;
    if (pend_va.size() == 0) begin
      $error("result with no item pending");
      errors++;
      return;
    end
    e_va = pend_va.pop_front(); e_vb = pend_vb.pop_front(); e_d = pend_d.pop_front();
    e_q = pend_q.pop_front(); e_el = pend_el.pop_front(); e_rot = pend_rot.pop_front();
    if (va !== e_va) begin $error("volt_alpha exp %h got %h", e_va, va); errors++; end
    if (vb !== e_vb) begin $error("volt_beta exp %h got %h", e_vb, vb); errors++; end
    if (d !== e_d) begin $error("meas_d exp %h got %h", e_d, d); errors++; end
    if (q !== e_q) begin $error("meas_q exp %h got %h", e_q, q); errors++; end
    if (el !== e_el) begin $error("elec_angle exp %h got %h", e_el, el); errors++; end
    if (rot !== e_rot) begin $error("rotor_angle exp %h got %h", e_rot, rot); errors++; end
  endfunction

  function int pending();
    return pend_va.size();
  endfunction
endclass

module tb_foc_current_loop_top;
  import foc_pkg::*;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic signed [11:0] phase_a_current_i, phase_b_current_i, phase_c_current_i;
  logic [15:0] mech_angle_i;
  logic [2:0] pwm_sector_i;
  logic signed [15:0] target_d_i, target_q_i;
  logic signed [15:0] volt_alpha_o, volt_beta_o, meas_d_o, meas_q_o;
  logic [15:0] elec_angle_o, rotor_angle_o;

  foc_current_loop_top u_top (.*);

  foc_scoreboard sb;

  // predictor copy of registers and loop state
  longint m_pp, m_shunt, m_gp, m_gi, m_lim;
  longint m_dacc, m_qacc, m_dprev, m_qprev;
  bit drain_mode;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #100ms;
    $display("FAIL foc_current_loop_top");
    $finish;
  end

  function automatic longint rshr(longint v, int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint sat16(longint v);
    return v < -32768 ? -32768 : (v > 32767 ? 32767 : v);
  endfunction

  function automatic longint qsine(longint u);
    longint u2, inner, mid;
    u2 = (u * u) >> 18;
    inner = longint'(SIN_B) - ((longint'(SIN_C) * u2) >> 18);
    mid = longint'(SIN_A) - ((inner * u2) >> 18);
    return (mid * u) >> 18;
  endfunction

  function automatic longint trig_q15(longint s28);
    longint v;
    v = rshr(s28, 13);
    return v > 32767 ? 32767 : v;
  endfunction

  function automatic longint pi_step(ref longint acc, ref longint prev, input longint err);
    longint lim;
    lim = m_lim <<< 16;
    acc = acc + m_gp * (err - prev) + m_gi * err;
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    prev = err;
    return rshr(acc, 16);
  endfunction

  task automatic predict_tick(input logic signed [11:0] pa, pb, pc, input logic [15:0] mech,
                              input logic [2:0] sec, input logic signed [15:0] td,
                              tq);
    longint ia, ib, ic, beta, s, c, fw, bw, d, q, vd, vq, va, vb, f;
    logic [15:0] elec;
    logic [1:0] quad;
    ia = pa; ib = pb; ic = pc;
    elec = 16'((longint'(mech) * m_pp) & 16'hffff);
    if (m_shunt != 0) begin
      if (sec == 1 || sec == 6) ia = -ib - ic;
      else if (sec == 2 || sec == 3) ib = -ia - ic;
      else if (sec == 4 || sec == 5) ic = -ia - ib;
    end
    beta = rshr((ia + 2 * ib) * 37837, 16);
    quad = elec[15:14];
    f = longint'(elec[13:0]) << 4;
    fw = trig_q15(qsine(f));
    bw = trig_q15(qsine(64'h40000 - f));
    case (quad)
      2'd0: begin s = fw; c = bw; end
      2'd1: begin s = bw; c = -fw; end
      2'd2: begin s = -fw; c = -bw; end
      default: begin s = -bw; c = fw; end
    endcase
    d = sat16(rshr(ia * c + beta * s, 15));
    q = sat16(rshr(-ia * s + beta * c, 15));
    vd = pi_step(m_dacc, m_dprev, longint'(td) - d);
    vq = pi_step(m_qacc, m_qprev, longint'(tq) - q);
    va = sat16(rshr(vd * c - vq * s, 15));
    vb = sat16(rshr(vd * s + vq * c, 15));
    sb.note(16'(va), 16'(vb), 16'(d), 16'(q), elec, mech);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_POLE_PAIRS: m_pp = val & 16'h3f;
      CFG_THREE_SHUNT: m_shunt = val & 16'h1;
      CFG_GAIN_P: m_gp = val;
      CFG_GAIN_I: m_gi = val;
      CFG_VOLTAGE_LIMIT: m_lim = val & 16'h7fff;
      default: ;
    endcase
  endtask

  // drop valid, then hold until every pending result is back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic send_tick(input logic signed [11:0] pa, pb, pc, input logic [15:0] mech,
                           input logic [2:0] sec, input logic signed [15:0] td, tq);
    if (!drain_mode && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    phase_a_current_i <= pa; phase_b_current_i <= pb; phase_c_current_i <= pc;
    mech_angle_i <= mech; pwm_sector_i <= sec; target_d_i <= td; target_q_i <= tq;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_tick(pa, pb, pc, mech, sec, td, tq);
  endtask

  task automatic send_random(input int n);
    int mode;
    repeat (n) begin
      mode = $urandom_range(0, 3);
      // small targets keep the loop out of saturation most of the time
      if (mode == 0)
        send_tick(12'($urandom), 12'($urandom), 12'($urandom), 16'($urandom),
                  3'($urandom), 16'($urandom), 16'($urandom));
      else
        send_tick(12'($urandom), 12'($urandom), 12'($urandom), 16'($urandom),
                  3'($urandom), 16'(int'($urandom_range(0, 4000)) - 2000),
                  16'(int'($urandom_range(0, 4000)) - 2000));
    end
  endtask

  // receiver: random stalls, checks on every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check(volt_alpha_o, volt_beta_o, meas_d_o, meas_q_o, elec_angle_o, rotor_angle_o);
  end

  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else if (!drain_mode && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 7) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int guard;
    sb = new();
    drain_mode = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0;
    phase_a_current_i = '0; phase_b_current_i = '0; phase_c_current_i = '0;
    mech_angle_i = '0; pwm_sector_i = '0; target_d_i = '0; target_q_i = '0;
    m_pp = 7; m_shunt = 1; m_gp = 2319; m_gi = 2319; m_lim = 28360;
    m_dacc = 0; m_qacc = 0; m_dprev = 0; m_qprev = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, every sector, zero pole pairs
    for (int s = 0; s < 8; s++)
      send_tick(12'sd100, -12'sd300, 12'sd200, 16'(s * 8192), 3'(s), 16'sd500, -16'sd500);
    send_tick(12'sh7ff, 12'sh7ff, 12'sh7ff, 16'hffff, 3'd0, 16'sh7fff, 16'sh7fff);
    send_tick(12'sh800, 12'sh800, 12'sh800, 16'h0000, 3'd7, 16'sh8000, 16'sh8000);
    send_tick(12'sh7ff, 12'sh800, 12'sh7ff, 16'h4000, 3'd2, 16'sh8000, 16'sh7fff);
    send_tick(12'sh800, 12'sh7ff, 12'sh800, 16'hc000, 3'd5, 16'sh7fff, 16'sh8000);
    wait_idle();
    cfg_write(CFG_POLE_PAIRS, 16'd0);
    cfg_write(CFG_THREE_SHUNT, 16'd0);
    cfg_write(CFG_GAIN_P, 16'hffff);
    cfg_write(CFG_GAIN_I, 16'hffff);
    cfg_write(CFG_VOLTAGE_LIMIT, 16'h7fff);
    send_tick(12'sh7ff, 12'sh800, 12'sh000, 16'h1234, 3'd1, 16'sh7fff, 16'sh8000);
    send_tick(12'sh000, 12'sh7ff, 12'sh800, 16'h8000, 3'd4, 16'sh8000, 16'sh7fff);
    send_random(100);
    wait_idle();

    // phases over register extremes and random settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          cfg_write(CFG_POLE_PAIRS, 16'd63); cfg_write(CFG_THREE_SHUNT, 16'd1);
          cfg_write(CFG_GAIN_P, 16'd0); cfg_write(CFG_GAIN_I, 16'd0);
          cfg_write(CFG_VOLTAGE_LIMIT, 16'd0);
        end
        1: begin
          cfg_write(CFG_POLE_PAIRS, 16'd1); cfg_write(CFG_GAIN_P, 16'd2319);
          cfg_write(CFG_GAIN_I, 16'd2319); cfg_write(CFG_VOLTAGE_LIMIT, 16'd28360);
        end
        default: begin
          cfg_write(CFG_POLE_PAIRS, 16'($urandom_range(1, 63)));
          cfg_write(CFG_THREE_SHUNT, 16'($urandom_range(0, 1)));
          cfg_write(CFG_GAIN_P, 16'($urandom));
          cfg_write(CFG_GAIN_I, 16'($urandom));
          cfg_write(CFG_VOLTAGE_LIMIT, 16'($urandom_range(0, 32767)));
        end
      endcase
      if (ph == 5) drain_mode = 1;
      send_random(120);
      wait_idle();
    end

    guard = 0;
    while (sb.pending() != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS foc_current_loop_top");
    end else begin
      $display("FAIL foc_current_loop_top");
    end
    $finish;
  end
endmodule
